// File: rtl/pcc_pkg.sv
package pcc_pkg;

  localparam int unsigned InTdataW  = 56;
  localparam int unsigned OutTdataW = 48;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;

  localparam logic signed [23:0] SlavePatternMax = 24'sh7FFFFF;

  typedef enum logic [2:0] {
    RegClockDivision  = 3'd0,
    RegMasterDelay    = 3'd1,
    RegSlaveLength    = 3'd2,
    RegPatternInc     = 3'd3,
    RegMasterOffset   = 3'd4,
    RegOffsetFixEn    = 3'd5,
    RegFixOffset      = 3'd6
  } reg_idx_e;

  localparam logic [8:0]         ClockDivisionRst = 9'd1;
  localparam logic [5:0]         MasterDelayRst   = 6'd1;
  localparam logic [6:0]         SlaveLengthRst   = 7'd16;
  localparam logic [13:0]        PatternIncRst    = 14'd1000;
  localparam logic signed [14:0] MasterOffsetRst  = 15'sd0;
  localparam logic               OffsetFixEnRst   = 1'b0;
  localparam logic signed [14:0] FixOffsetRst     = 15'sd0;

  typedef struct packed {
    logic [8:0]         clock_division;
    logic [5:0]         master_delay;
    logic [6:0]         slave_length;
    logic [13:0]        pattern_increment;
    logic signed [14:0] master_pattern_offset;
    logic               offset_fix_enable;
    logic signed [14:0] fix_offset;
  } cfg_t;

  typedef struct packed {
    logic               reset_edge;
    logic               clock_edge;
    logic signed [14:0] pattern_in;
    logic signed [14:0] master_pattern_in;
    logic [9:0]         phrase_length_in;
    logic [9:0]         phrase_duration_in;
  } item_t;

  typedef struct packed {
    logic               master_reset_trig;
    logic               master_clock_trig;
    logic signed [14:0] master_pattern_out;
    logic               slave_reset_trig;
    logic               slave_clock_trig;
    logic               phrase_start_trig;
    logic               pattern_start_trig;
    logic signed [23:0] slave_pattern_out;
  } result_t;

endpackage

// File: rtl/pcc_cfg.sv
module pcc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcc_pkg::ApbAddrW-1:0]    paddr,
  input  logic [pcc_pkg::ApbDataW-1:0]    pwdata,
  output logic [pcc_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready,
  output pcc_pkg::cfg_t                   cfg_o
);
  import pcc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegClockDivision: cfg_d.clock_division        = pwdata[8:0];
        RegMasterDelay:   cfg_d.master_delay          = pwdata[5:0];
        RegSlaveLength:   cfg_d.slave_length          = pwdata[6:0];
        RegPatternInc:    cfg_d.pattern_increment     = pwdata[13:0];
        RegMasterOffset:  cfg_d.master_pattern_offset = pwdata[14:0];
        RegOffsetFixEn:   cfg_d.offset_fix_enable     = pwdata[0];
        RegFixOffset:     cfg_d.fix_offset            = pwdata[14:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegClockDivision: prdata = 32'(cfg_q.clock_division);
      RegMasterDelay:   prdata = 32'(cfg_q.master_delay);
      RegSlaveLength:   prdata = 32'(cfg_q.slave_length);
      RegPatternInc:    prdata = 32'(cfg_q.pattern_increment);
      RegMasterOffset:  prdata = 32'(signed'(cfg_q.master_pattern_offset));
      RegOffsetFixEn:   prdata = 32'(cfg_q.offset_fix_enable);
      RegFixOffset:     prdata = 32'(signed'(cfg_q.fix_offset));
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_division        <= ClockDivisionRst;
      cfg_q.master_delay          <= MasterDelayRst;
      cfg_q.slave_length          <= SlaveLengthRst;
      cfg_q.pattern_increment     <= PatternIncRst;
      cfg_q.master_pattern_offset <= MasterOffsetRst;
      cfg_q.offset_fix_enable     <= OffsetFixEnRst;
      cfg_q.fix_offset            <= FixOffsetRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/pcc_core.sv
module pcc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  pcc_pkg::item_t    item_i,
  input  pcc_pkg::cfg_t     cfg_i,
  output pcc_pkg::result_t  res_o
);
  import pcc_pkg::*;

  logic [14:0]        pdc_q, pdc_d, plc_q, plc_d, slc_q, slc_d;
  logic [8:0]         dvc_q, dvc_d;
  logic [5:0]         dc_q, dc_d;
  logic               rp_q, rp_d;
  logic signed [23:0] sp_q, sp_d;
  logic signed [14:0] hold_q, hold_d;

  // values loaded by master processing
  logic [15:0]        prod, prod_m1;
  logic [14:0]        mp_slc, mp_plc, mp_pdc;
  logic [8:0]         mp_dvc;
  logic signed [23:0] fix_ext, mp_sp, ph_sp;
  logic signed [24:0] inc_sum;
  logic [23:0]        inc_sat;

  assign prod    = 16'(cfg_i.slave_length) * 16'(cfg_i.clock_division);
  assign prod_m1 = prod - 16'd1;
  assign mp_slc  = prod_m1[14:0];
  assign mp_plc  = (item_i.phrase_length_in == 10'd0) ? mp_slc :
                   15'(item_i.phrase_length_in - 10'd1);
  assign mp_pdc  = (item_i.phrase_duration_in == 10'd0) ? mp_plc :
                   15'(item_i.phrase_duration_in - 10'd1);
  assign mp_dvc  = cfg_i.clock_division - 9'd1;
  assign fix_ext = cfg_i.offset_fix_enable ? 24'(cfg_i.fix_offset) : 24'sd0;
  assign ph_sp   = 24'(item_i.master_pattern_in) + fix_ext;
  assign mp_sp   = ph_sp + 24'(cfg_i.master_pattern_offset);
  assign inc_sum = 25'(sp_q) + 25'(cfg_i.pattern_increment);
  assign inc_sat = (inc_sum[24] != inc_sum[23]) ? SlavePatternMax : inc_sum[23:0];

  always_comb begin
    pdc_d  = pdc_q;
    plc_d  = plc_q;
    slc_d  = slc_q;
    dvc_d  = dvc_q;
    dc_d   = dc_q;
    rp_d   = rp_q;
    sp_d   = sp_q;
    hold_d = hold_q;
    res_o  = '0;

    // delay countdown
    if (dc_d != 6'd0) begin
      dc_d = dc_d - 6'd1;
      if (dc_d == 6'd0) begin
        sp_d  = mp_sp;
        slc_d = mp_slc;
        plc_d = mp_plc;
        pdc_d = mp_pdc;
        dvc_d = mp_dvc;
        res_o.slave_reset_trig   = 1'b1;
        res_o.slave_clock_trig   = 1'b1;
        res_o.phrase_start_trig  = 1'b1;
        res_o.pattern_start_trig = 1'b1;
      end
    end

    if (item_i.reset_edge) begin
      rp_d = 1'b1;
    end

    if (item_i.clock_edge) begin
      if (rp_d) begin
        hold_d = item_i.pattern_in;
        res_o.master_reset_trig = 1'b1;
        pdc_d = '0;
        plc_d = '0;
        slc_d = '0;
        dvc_d = '0;
        rp_d  = 1'b0;
      end
      if (pdc_d == 15'd0) begin
        res_o.master_clock_trig = 1'b1;
        dc_d = cfg_i.master_delay;
        if (dc_d == 6'd0) begin
          sp_d  = mp_sp;
          slc_d = mp_slc;
          plc_d = mp_plc;
          pdc_d = mp_pdc;
          dvc_d = mp_dvc;
          res_o.slave_reset_trig   = 1'b1;
          res_o.slave_clock_trig   = 1'b1;
          res_o.phrase_start_trig  = 1'b1;
          res_o.pattern_start_trig = 1'b1;
        end
      end else begin
        if (plc_d == 15'd0) begin
          plc_d = (item_i.phrase_length_in == 10'd0) ? 15'(cfg_i.slave_length) :
                  15'(item_i.phrase_length_in);
          sp_d  = ph_sp;
          slc_d = prod[14:0];
          dvc_d = '0;
          res_o.slave_reset_trig   = 1'b1;
          res_o.pattern_start_trig = 1'b1;
        end else if (slc_d == 15'd0) begin
          sp_d  = inc_sat;
          slc_d = prod[14:0];
          dvc_d = '0;
          res_o.slave_reset_trig = 1'b1;
        end
        plc_d = plc_d - 15'd1;
        slc_d = slc_d - 15'd1;
        pdc_d = pdc_d - 15'd1;
        if (dvc_d == 9'd0) begin
          res_o.slave_clock_trig = 1'b1;
          dvc_d = cfg_i.clock_division;
        end
        dvc_d = dvc_d - 9'd1;
      end
    end

    res_o.master_pattern_out = hold_d;
    res_o.slave_pattern_out  = sp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pdc_q  <= '0;
      plc_q  <= '0;
      slc_q  <= '0;
      dvc_q  <= '0;
      dc_q   <= '0;
      rp_q   <= 1'b0;
      sp_q   <= '0;
      hold_q <= '0;
    end else if (step_i) begin
      pdc_q  <= pdc_d;
      plc_q  <= plc_d;
      slc_q  <= slc_d;
      dvc_q  <= dvc_d;
      dc_q   <= dc_d;
      rp_q   <= rp_d;
      sp_q   <= sp_d;
      hold_q <= hold_d;
    end
  end

endmodule

// File: rtl/phrase_sequencer_clock_controller.sv
// Phrase sequencer clock controller: one input beat is one sample tick and gives exactly one
// output beat. Beats pass an input register and an output register with the tick's counter
// update in between, so the block takes a beat every cycle while the output side is not
// stalled. The result beat is loaded into the output register when the tick is processed and
// is held there until the output side takes it. The user must write the registers over the
// APB port only while no tick is in flight; the block itself does not enforce this. They sit
// at byte addresses 4*i in the order clock_division, master_delay, slave_length,
// pattern_increment, master_pattern_offset, offset_fix_enable, fix_offset.
module phrase_sequencer_clock_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // reset_edge[0], clock_edge[1], pattern_in[16:2], master_pattern_in[31:17],
  // phrase_length_in[41:32], phrase_duration_in[51:42], zero[55:52]
  input  logic [pcc_pkg::InTdataW-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // master_reset_trig[0], master_clock_trig[1], master_pattern_out[16:2],
  // slave_reset_trig[17], slave_clock_trig[18], phrase_start_trig[19],
  // pattern_start_trig[20], slave_pattern_out[44:21], zero[47:45]
  output logic [pcc_pkg::OutTdataW-1:0]       m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcc_pkg::ApbAddrW-1:0]        paddr,
  input  logic [pcc_pkg::ApbDataW-1:0]        pwdata,
  output logic [pcc_pkg::ApbDataW-1:0]        prdata,
  output logic                                pready
);
  import pcc_pkg::*;

  cfg_t    cfg;
  item_t   in_q, in_beat;
  logic    in_valid_q, in_valid_d;
  result_t res, out_q;
  logic    out_valid_q, out_valid_d;
  logic    advance, in_acc;

  pcc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input beat unpack
  assign in_beat.reset_edge         = s_axis_tdata[0];
  assign in_beat.clock_edge         = s_axis_tdata[1];
  assign in_beat.pattern_in         = s_axis_tdata[16:2];
  assign in_beat.master_pattern_in  = s_axis_tdata[31:17];
  assign in_beat.phrase_length_in   = s_axis_tdata[41:32];
  assign in_beat.phrase_duration_in = s_axis_tdata[51:42];

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_beat;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          out_q.slave_pattern_out,
                          out_q.pattern_start_trig,
                          out_q.phrase_start_trig,
                          out_q.slave_clock_trig,
                          out_q.slave_reset_trig,
                          out_q.master_pattern_out,
                          out_q.master_clock_trig,
                          out_q.master_reset_trig};

`ifndef NO_ASSERTIONS
  // a master reset always clears the phrase count, so a master clock follows in the same tick
  a_reset_gives_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.master_reset_trig |-> out_q.master_clock_trig)
    else $error("master reset without master clock");

  // a new pattern always restarts the slave
  a_pattern_resets_slave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pattern_start_trig |-> out_q.slave_reset_trig)
    else $error("pattern start without slave reset");

  // phrase start comes only from master processing, which fires all slave triggers
  a_phrase_start_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.phrase_start_trig |->
      out_q.slave_clock_trig && out_q.pattern_start_trig)
    else $error("phrase start without slave clock and pattern start");

  // a processed tick shows up at the output on the next edge
  a_advance_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed tick lost");
`endif

endmodule
